[hdl/rlp_pkg.sv]
// shared types, codes and keyword table of the request line parser
package rlp_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_GET    = 2'd1,
		KIND_PUT    = 2'd2,
		KIND_HEALTH = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_MALFORMED = 3'd1,
		ERR_GET_ARITY = 3'd2,
		ERR_PUT_ARITY = 3'd3,
		ERR_BAD_COUNT = 3'd4,
		ERR_UNKNOWN   = 3'd5
	} err_code_t;

	localparam int CAND_GET    = 0;
	localparam int CAND_PUT    = 1;
	localparam int CAND_HEALTH = 2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_done;
	} request_t;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  name_byte;
		logic [1:0]  request_kind;
		logic [2:0]  error_code;
		logic [63:0] put_count;
		logic        name_safe;
	} result_t;

	// classified transaction passed from front to back
	typedef struct packed {
		logic [7:0] char_code;
		logic       done;
		logic       space;
		logic       dot;
		logic       slash;
		logic       digit;
		logic [3:0] digit_val;
	} class_t;

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] r;
		r = 3'd3;
		if (k == 2'(CAND_HEALTH)) r = 3'd6;
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			2'(CAND_GET): begin
				case (pos)
					3'd0: r = "G";
					3'd1: r = "E";
					3'd2: r = "T";
					default: r = 8'h00;
				endcase
			end
			2'(CAND_PUT): begin
				case (pos)
					3'd0: r = "P";
					3'd1: r = "U";
					3'd2: r = "T";
					default: r = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0: r = "H";
					3'd1: r = "E";
					3'd2: r = "A";
					3'd3: r = "L";
					3'd4: r = "T";
					3'd5: r = "H";
					default: r = 8'h00;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

[hdl/rlp_front.sv]
// front end: sorts each incoming byte into its character classes
module rlp_front (
	input  rlp_pkg::request_t request,
	output rlp_pkg::class_t   classed
);

	logic [7:0] c;
	logic [7:0] off;

	assign c   = request.char_code;
	assign off = c - rlp_pkg::CHAR_ZERO;

	always_comb begin
		classed.char_code = c;
		classed.done      = request.line_done;
		classed.space     = (c == rlp_pkg::CHAR_SPACE);
		classed.dot       = (c == rlp_pkg::CHAR_DOT);
		classed.slash     = (c == rlp_pkg::CHAR_SLASH);
		classed.digit     = (c >= rlp_pkg::CHAR_ZERO) && (c <= rlp_pkg::CHAR_NINE);
		classed.digit_val = off[3:0];
	end

endmodule

[hdl/rlp_queue.sv]
// short queue of classified transactions between front and back
module rlp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rlp_pkg::class_t  wr_data,
	output logic             full,
	input  logic             rd,
	output logic             valid,
	output rlp_pkg::class_t  rd_data
);

	rlp_pkg::class_t                 mem_q [rlp_pkg::QDEPTH];
	logic [rlp_pkg::QPTR_W-1:0]      wp_q, rp_q;
	logic [rlp_pkg::QPTR_W:0]        cnt_q;
	logic                            do_wr, do_rd;

	assign full    = (cnt_q == (rlp_pkg::QPTR_W+1)'(rlp_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && valid;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/rlp_back.sv]
// back end: token tracking, keyword match, count, verdict and result queue
module rlp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rlp_pkg::class_t  in_data,
	output logic             in_take,
	output logic             empty,
	input  logic             pop,
	output rlp_pkg::result_t result
);

	logic [2:0]  tok_cnt_q;
	logic        in_tok_q;
	logic [2:0]  kw_pos_q;
	logic [2:0]  cand_q;
	logic [63:0] cnt_val_q;
	logic        cnt_bad_q;
	logic [1:0]  nm_len_q;
	logic        nm_dots_q;
	logic        nm_slash_q;

	rlp_pkg::result_t out_q [2];
	logic             owp_q, orp_q;
	logic [1:0]       ocnt_q;

	logic [2:0]       tc_n;
	logic [2:0]       close_mask;
	logic [2:0]       hit;
	logic [67:0]      acc;
	logic             name_ok;
	logic [2:0]       cand_v;
	logic             res_valid;
	rlp_pkg::result_t res;
	logic             do_pop, do_push;

	assign in_take = in_valid && (ocnt_q != 2'd2);
	assign tc_n    = in_tok_q ? tok_cnt_q : ((tok_cnt_q < 3'd4) ? tok_cnt_q + 3'd1 : 3'd4);
	assign acc     = ({4'b0, cnt_val_q} << 3) + ({4'b0, cnt_val_q} << 1)
	                 + {64'b0, in_data.digit_val};
	assign name_ok = !nm_slash_q && !(nm_dots_q && nm_len_q >= 2'd1 && nm_len_q <= 2'd2);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			close_mask[k] = (kw_pos_q == rlp_pkg::kw_len(2'(k)));
			hit[k] = (kw_pos_q < rlp_pkg::kw_len(2'(k)))
			         && (rlp_pkg::kw_char(2'(k), kw_pos_q) == in_data.char_code);
		end
	end

	// result of the current transaction
	always_comb begin
		cand_v    = (tok_cnt_q == 3'd1 && in_tok_q) ? (cand_q & close_mask) : cand_q;
		res       = '0;
		res_valid = 1'b0;
		if (in_data.done) begin
			res_valid       = 1'b1;
			res.record_kind = 1'b1;
			if (tok_cnt_q == 3'd0) begin
				res.error_code = rlp_pkg::ERR_MALFORMED;
			end else if (cand_v[rlp_pkg::CAND_GET]) begin
				if (tok_cnt_q != 3'd2) res.error_code = rlp_pkg::ERR_GET_ARITY;
				else begin
					res.request_kind = rlp_pkg::KIND_GET;
					res.name_safe    = name_ok;
				end
			end else if (cand_v[rlp_pkg::CAND_PUT]) begin
				if (tok_cnt_q != 3'd3) res.error_code = rlp_pkg::ERR_PUT_ARITY;
				else if (cnt_bad_q) res.error_code = rlp_pkg::ERR_BAD_COUNT;
				else begin
					res.request_kind = rlp_pkg::KIND_PUT;
					res.put_count    = cnt_val_q;
					res.name_safe    = name_ok;
				end
			end else if (cand_v[rlp_pkg::CAND_HEALTH]) begin
				if (tok_cnt_q != 3'd1) res.error_code = rlp_pkg::ERR_MALFORMED;
				else res.request_kind = rlp_pkg::KIND_HEALTH;
			end else begin
				res.error_code = rlp_pkg::ERR_UNKNOWN;
			end
		end else if (!in_data.space && tc_n == 3'd2
		             && (cand_q[rlp_pkg::CAND_GET] || cand_q[rlp_pkg::CAND_PUT])) begin
			res_valid     = 1'b1;
			res.name_byte = in_data.char_code;
		end
	end

	assign do_push = in_take && res_valid;
	assign do_pop  = pop && !empty;
	assign empty   = (ocnt_q == 2'd0);
	assign result  = out_q[orp_q];

	always_ff @(posedge clk) begin
		if (do_push) out_q[owp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q      <= 1'b0;
			orp_q      <= 1'b0;
			ocnt_q     <= 2'd0;
			tok_cnt_q  <= 3'd0;
			in_tok_q   <= 1'b0;
			kw_pos_q   <= 3'd0;
			cand_q     <= 3'b111;
			cnt_val_q  <= '0;
			cnt_bad_q  <= 1'b0;
			nm_len_q   <= 2'd0;
			nm_dots_q  <= 1'b1;
			nm_slash_q <= 1'b0;
		end else begin
			if (do_push) owp_q <= ~owp_q;
			if (do_pop) orp_q <= ~orp_q;
			case ({do_push, do_pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
			if (in_take) begin
				if (in_data.done) begin
					tok_cnt_q  <= 3'd0;
					in_tok_q   <= 1'b0;
					kw_pos_q   <= 3'd0;
					cand_q     <= 3'b111;
					cnt_val_q  <= '0;
					cnt_bad_q  <= 1'b0;
					nm_len_q   <= 2'd0;
					nm_dots_q  <= 1'b1;
					nm_slash_q <= 1'b0;
				end else if (in_data.space) begin
					if (in_tok_q && tok_cnt_q == 3'd1) cand_q <= cand_q & close_mask;
					in_tok_q <= 1'b0;
				end else begin
					in_tok_q  <= 1'b1;
					tok_cnt_q <= tc_n;
					if (tc_n == 3'd1) begin
						cand_q <= cand_q & hit;
						if (kw_pos_q != 3'd7) kw_pos_q <= kw_pos_q + 3'd1;
					end else if (tc_n == 3'd2) begin
						if (nm_len_q != 2'd3) nm_len_q <= nm_len_q + 2'd1;
						if (!in_data.dot) nm_dots_q <= 1'b0;
						if (in_data.slash) nm_slash_q <= 1'b1;
					end else if (tc_n == 3'd3 && !cnt_bad_q) begin
						if (!in_data.digit || acc[67:64] != 4'd0) cnt_bad_q <= 1'b1;
						else cnt_val_q <= acc[63:0];
					end
				end
			end
		end
	end

endmodule

[hdl/request_line_parser_top.sv]
// top level of the request line parser: front classifier, queue, back end
//
// channel   direction  handshake             payload
// request   in         push / full           char_code, line_done
// result    out        pop / empty           record, filename byte, verdict
//
// one byte transaction per cycle sustained while pop keeps the result queue from filling; the
// front classifier is combinational, an accepted transaction is written into the middle
// queue and taken from it by the back end, which writes its result into the result queue
// results wait in a two-entry queue at the back end, so a stalled consumer fills it first
// and then the four-entry middle queue, after which full rises
// arst_n clears all control state; the parser starts at the beginning of a line
// the 64-bit count update (times ten plus digit) sets the longest path in the back end
module request_line_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rlp_pkg::request_t request,
	output logic              empty,
	input  logic              pop,
	output rlp_pkg::result_t  result
);

	rlp_pkg::class_t classed;
	rlp_pkg::class_t mid_data;
	logic            mid_valid;
	logic            mid_take;

	// byte classification, no state
	rlp_front u_front (
		.request (request),
		.classed (classed)
	);

	// decouples input acceptance from back end stalls
	rlp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (classed),
		.full    (full),
		.rd      (mid_take),
		.valid   (mid_valid),
		.rd_data (mid_data)
	);

	// parsing state and result queue
	rlp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_data  (mid_data),
		.in_take  (mid_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// a filename byte record carries no verdict
	a_byte_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.record_kind) |->
		(result.request_kind == rlp_pkg::KIND_NONE && result.error_code == rlp_pkg::ERR_OK))
		else $error("byte record carries verdict fields");

	// an error verdict names no request
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.error_code != rlp_pkg::ERR_OK) |->
		(result.request_kind == rlp_pkg::KIND_NONE))
		else $error("error verdict with request kind");

	// only a good put carries a count
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.request_kind != rlp_pkg::KIND_PUT) |-> (result.put_count == '0))
		else $error("count outside a put verdict");

	// a result waiting and not taken stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result lost");

endmodule

[verif/request_line_checker.sv]
// scoreboard for the request line parser: predicts results and compares them
module request_line_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  rlp_pkg::request_t request,
	input  logic              empty,
	input  logic              pop,
	input  rlp_pkg::result_t  result,
	output int                fail_count,
	output int                pending,
	output int                verdicts_seen,
	output int                bytes_seen
);
	import rlp_pkg::*;

	result_t expected_q[$];

	logic [2:0]  tok_n;
	logic        in_tok;
	logic [2:0]  kw_pos;
	logic [2:0]  kw_cand;
	logic [63:0] cnt_val;
	logic        cnt_bad;
	logic [1:0]  fname_len;
	logic        fname_dots;
	logic        fname_slash;

	task automatic clear_line();
		tok_n = 0;
		in_tok = 0;
		kw_pos = 0;
		kw_cand = 3'b111;
		cnt_val = 0;
		cnt_bad = 0;
		fname_len = 0;
		fname_dots = 1;
		fname_slash = 0;
	endtask

	// drop keywords whose length differs from the first token's
	task automatic close_keyword();
		for (int k = 0; k < 3; k++)
			if (kw_pos != kw_len(2'(k))) kw_cand[k] = 0;
	endtask

	task automatic parse_char(input request_t req);
		result_t r;
		logic    ok_name;
		logic [3:0] d;
		r = '0;
		if (req.line_done) begin
			ok_name = !fname_slash && !(fname_dots && fname_len >= 1 && fname_len <= 2);
			if (tok_n == 1 && in_tok) close_keyword();
			r.record_kind = 1;
			if (tok_n == 0) r.error_code = ERR_MALFORMED;
			else if (kw_cand[CAND_GET]) begin
				if (tok_n != 2) r.error_code = ERR_GET_ARITY;
				else begin
					r.request_kind = KIND_GET;
					r.name_safe = ok_name;
				end
			end else if (kw_cand[CAND_PUT]) begin
				if (tok_n != 3) r.error_code = ERR_PUT_ARITY;
				else if (cnt_bad) r.error_code = ERR_BAD_COUNT;
				else begin
					r.request_kind = KIND_PUT;
					r.put_count = cnt_val;
					r.name_safe = ok_name;
				end
			end else if (kw_cand[CAND_HEALTH]) begin
				if (tok_n != 1) r.error_code = ERR_MALFORMED;
				else r.request_kind = KIND_HEALTH;
			end else r.error_code = ERR_UNKNOWN;
			expected_q = {expected_q, r};
			clear_line();
			return;
		end
		if (req.char_code == CHAR_SPACE) begin
			if (in_tok && tok_n == 1) close_keyword();
			in_tok = 0;
			return;
		end
		if (!in_tok) begin
			in_tok = 1;
			if (tok_n < 4) tok_n++;
		end
		if (tok_n == 1) begin
			for (int k = 0; k < 3; k++)
				if (kw_pos >= kw_len(2'(k)) || kw_char(2'(k), kw_pos) != req.char_code)
					kw_cand[k] = 0;
			if (kw_pos < 7) kw_pos++;
		end else if (tok_n == 2) begin
			if (fname_len < 3) fname_len++;
			if (req.char_code != CHAR_DOT) fname_dots = 0;
			if (req.char_code == CHAR_SLASH) fname_slash = 1;
			if (kw_cand[CAND_GET] || kw_cand[CAND_PUT]) begin
				r.name_byte = req.char_code;
				expected_q = {expected_q, r};
			end
		end else if (tok_n == 3 && !cnt_bad) begin
			if (req.char_code < CHAR_ZERO || req.char_code > CHAR_NINE) cnt_bad = 1;
			else begin
				d = 4'(req.char_code - CHAR_ZERO);
				if (cnt_val > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 10) cnt_bad = 1;
				else cnt_val = cnt_val * 10 + 64'(d);
			end
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			$error("unexpected result transaction %h", got);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		if (got.record_kind) verdicts_seen++;
		else bytes_seen++;
		if (got.record_kind !== want.record_kind) begin
			$error("record_kind exp %0d got %0d", want.record_kind, got.record_kind);
			fail_count++;
		end
		if (got.name_byte !== want.name_byte) begin
			$error("name_byte exp %h got %h", want.name_byte, got.name_byte);
			fail_count++;
		end
		if (got.request_kind !== want.request_kind) begin
			$error("request_kind exp %0d got %0d", want.request_kind, got.request_kind);
			fail_count++;
		end
		if (got.error_code !== want.error_code) begin
			$error("error_code exp %0d got %0d", want.error_code, got.error_code);
			fail_count++;
		end
		if (got.put_count !== want.put_count) begin
			$error("put_count exp %0d got %0d", want.put_count, got.put_count);
			fail_count++;
		end
		if (got.name_safe !== want.name_safe) begin
			$error("name_safe exp %0d got %0d", want.name_safe, got.name_safe);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		verdicts_seen = 0;
		bytes_seen = 0;
		clear_line();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) compare_result(result);
			if (push && !full) parse_char(request);
			pending = expected_q.size();
		end
	end
endmodule

[verif/request_line_parser_top_tb.sv]
// testbench top for the request line parser: stimulus, reset, watchdog and verdict
module request_line_parser_top_tb;
	import rlp_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     push = 0;
	logic     full;
	request_t request = '0;
	logic     empty;
	logic     pop = 0;
	result_t  result;

	int fail_count, pending, verdicts_seen, bytes_seen;
	int push_idle_pct = 0, pop_idle_pct = 0;
	int stall_cycles = 0;
	int sent = 0;

	always #2 clk = ~clk;

	request_line_parser_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .result(result)
	);

	request_line_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .result(result), .fail_count(fail_count),
		.pending(pending), .verdicts_seen(verdicts_seen), .bytes_seen(bytes_seen)
	);

	// receiver: pop decided at each falling edge from the current idle rate
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_idle_pct);
	end

	// watchdog: counts cycles with no transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", stall_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// one transaction on the request side; push held high across back-to-back bytes
	task automatic send_byte(input logic [7:0] c, input logic done);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		request <= '{char_code: c, line_done: done};
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	function automatic string rand_name();
		string s;
		int    n;
		s = "";
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			case ($urandom_range(5))
				0: s = {s, "."};
				1: s = {s, "/"};
				2: s = {s, string'(8'($urandom_range(8'h21, 8'hff)))};
				default: s = {s, string'(8'($urandom_range("a", "z")))};
			endcase
		if ($urandom_range(7) == 0) s = ($urandom_range(1)) ? "." : "..";
		return s;
	endfunction

	function automatic string rand_count();
		string s;
		int    n;
		s = "";
		case ($urandom_range(7))
			0: return "18446744073709551615";
			1: return "18446744073709551616";
			2: return "99999999999999999999999";
			default: n = $urandom_range(1, 8);
		endcase
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
		if ($urandom_range(9) == 0) s = {s, "x"};
		return s;
	endfunction

	function automatic string rand_space();
		return ($urandom_range(3) == 0) ? "  " : " ";
	endfunction

	// mostly well-formed lines with random content, some broken or noisy
	task automatic random_line();
		string s;
		case ($urandom_range(9))
			0, 1, 2: s = {"GET", rand_space(), rand_name()};
			3, 4, 5: s = {"PUT", rand_space(), rand_name(), rand_space(), rand_count()};
			6: s = "HEALTH";
			7: s = {"GET", " ", rand_name(), " ", rand_count()};
			8: s = {"PUT", " ", rand_name()};
			default: begin
				s = "";
				for (int i = 0; i < $urandom_range(0, 10); i++)
					s = {s, string'(8'($urandom_range(255)))};
			end
		endcase
		if ($urandom_range(5) == 0) s = {" ", s};
		if ($urandom_range(5) == 0) s = {s, " "};
		send_line(s);
	endtask

	task automatic random_phase(input int p_idle, input int r_idle, input int n);
		push_idle_pct = p_idle;
		pop_idle_pct = r_idle;
		for (int i = 0; i < n; ) begin
			int before_n;
			before_n = sent;
			random_line();
			i += sent - before_n;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed lines: every keyword, arity errors, count extremes, unsafe names
		send_line("");
		send_line("   ");
		send_line("HEALTH");
		send_line("HEALTH x");
		send_line("GET a/b");
		send_line("GET ..");
		send_line("GET .");
		send_line("GET ...");
		send_line("PUT f 18446744073709551615");
		send_line("PUT f 18446744073709551616");
		send_line("PUT f 0");
		send_line("PUT f 1a");
		send_line("GET");
		send_line("PUT f");
		send_line("GET a b c d e");
		send_line("GETX y");
		send_line("HEAL");
		send_text("GET ");
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);

		random_phase(20, 52, 500);
		random_phase(52, 20, 500);
		random_phase(0, 0, 500);
		push <= 0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d byte transactions; checked %0d verdicts and %0d filename bytes",
			sent, verdicts_seen, bytes_seen);
		if (fail_count == 0 && pending == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
